// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RDB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RDB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rdb_pkg.sv =====
`timescale 1ns / 1ps
package rdb_pkg;

    localparam int ROW_W     = 7;
    localparam int COL_W     = 7;
    localparam int PIX_W     = 24;
    localparam int H_W       = 8;
    localparam int DIM_W     = 8;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int FRAC_W    = 12;
    localparam int COEF_W    = 13;
    localparam int PROD_W    = COEF_W + H_W;
    localparam int ROM_DEPTH = 256;
    localparam int DIM_MAX   = 128;
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(DIM_MAX);

    localparam logic [REG_IDX_W-1:0] REG_ROWS = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_COLS = 1'd1;

    typedef enum logic
    {
        CMD_LOAD   = 1'b0,
        CMD_RENDER = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } dims_t;

    typedef struct packed
    {
        cmd_t             cmd;
        logic             interior;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pixel;
        logic [H_W-1:0]   height;
    } item_t;

    typedef logic [COEF_W-1:0] coef_rom_t [ROM_DEPTH];

    // Magnitude of tan(a - asin(sin a / 1.33)), a = atan(m), in Q(FRAC_W).
    // Exact integer form: square root by bit pairs, rounded quotient by
    // restoring shift-subtract. Evaluated at elaboration only.
    function automatic logic [COEF_W-1:0] coef_mag(input logic [63:0] m);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] dividend;
        logic [64:0] divisor;
        logic [64:0] rem;
        logic [63:0] quo;
        x = (64'd17689 + 64'd7689 * m * m) << 32;
        res = 64'd0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        num = (m * (res - 64'd6553600)) << FRAC_W;
        den = res + 64'd6553600 * m * m;
        dividend = 64'd2 * num + den;
        divisor = {den, 1'b0};
        rem = 65'd0;
        quo = 64'd0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], dividend[i]};
            if (rem >= divisor)
            begin
                rem = rem - divisor;
                quo[i] = 1'b1;
            end
        end
        if (m == 64'd0)
        begin
            quo = 64'd0;
        end
        return quo[COEF_W-1:0];
    endfunction

    function automatic coef_rom_t build_coef_rom();
        coef_rom_t rom;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            rom[i] = coef_mag(64'(i));
        end
        return rom;
    endfunction

endpackage

// ===== hw/rtl/rdb_front.sv =====
`timescale 1ns / 1ps
module rdb_front
    import rdb_pkg::*;
(
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             cmd,
    input  logic [ROW_W-1:0] row,
    input  logic [COL_W-1:0] col,
    input  logic [PIX_W-1:0] pixel_in,
    input  logic [H_W-1:0]   height_in,
    input  dims_t            dims,
    input  logic             q_full,
    output logic             q_push,
    output item_t            q_item
);

    logic [DIM_W:0] row_lim;
    logic [DIM_W:0] col_lim;
    logic           row_in;
    logic           col_in;

    // Interior: 1 <= pos and pos + 2 <= size.
    assign row_lim = (DIM_W+1)'(row) + (DIM_W+1)'(2);
    assign col_lim = (DIM_W+1)'(col) + (DIM_W+1)'(2);
    assign row_in  = (row != '0) && (row_lim <= {1'b0, dims.rows});
    assign col_in  = (col != '0) && (col_lim <= {1'b0, dims.cols});

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.cmd      = cmd_t'(cmd);
        q_item.interior = (cmd_t'(cmd) == CMD_RENDER) && row_in && col_in;
        q_item.row      = row;
        q_item.col      = col;
        q_item.pixel    = pixel_in;
        q_item.height   = height_in;
    end

endmodule

// ===== hw/rtl/rdb_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rdb_queue
    import rdb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    `RDB_ASSERT_NOW(a_q_no_overflow, push, !full, "push into full queue")
    `RDB_ASSERT_NEXT(a_q_drain, do_pop && !push,
        count_reg == $past(count_reg) - CNT_W'(1), "queue count lost on pop")

endmodule

// ===== hw/rtl/rdb_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rdb_back
    import rdb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dims_t            dims,
    input  logic             q_not_empty,
    input  item_t            q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] pixel_out,
    output logic [ROW_W-1:0] src_row,
    output logic [COL_W-1:0] src_col
);

    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam coef_rom_t COEF_ROM = build_coef_rom();

    typedef enum logic [6:0]
    {
        S_IDLE = 7'b0000001,
        S_HC   = 7'b0000010,
        S_HD   = 7'b0000100,
        S_HR   = 7'b0001000,
        S_ROW  = 7'b0010000,
        S_COL  = 7'b0100000,
        S_PIX  = 7'b1000000
    } state_t;

    logic [PIX_W-1:0] frame_mem [STORE_DEPTH];
    logic [H_W-1:0]   height_mem [STORE_DEPTH];

    state_t            state_reg;
    state_t            state_next;
    logic [PIX_W-1:0]  frame_q_reg;
    logic [H_W-1:0]    height_q_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [H_W-1:0]    hc_reg;
    logic [COEF_W-1:0] coef_r_reg;
    logic [COEF_W-1:0] coef_c_reg;
    logic              neg_r_reg;
    logic              neg_c_reg;
    logic [PROD_W-1:0] prod_r_reg;
    logic [PROD_W-1:0] prod_c_reg;
    logic [ROW_W-1:0]  sr_reg;
    logic [COL_W-1:0]  sc_reg;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  pixel_out_reg;
    logic [ROW_W-1:0]  src_row_reg;
    logic [COL_W-1:0]  src_col_reg;

    logic              frame_we;
    logic              frame_re;
    logic [ADDR_W-1:0] frame_addr;
    logic              height_we;
    logic              height_re;
    logic [ADDR_W-1:0] height_addr;
    logic signed [H_W:0] diff;
    logic [H_W-1:0]    diff_mag;
    logic              out_free;
    logic              out_load;
    logic [ROW_W-1:0]  sr_calc;
    logic [COL_W-1:0]  sc_calc;

    // Rounded displacement, ties away from zero; fall back to base when out of frame.
    function automatic logic [ROW_W-1:0] fix_coord(
        input logic [ROW_W-1:0]  base,
        input logic              neg,
        input logic [PROD_W-1:0] prod,
        input logic [DIM_W-1:0]  lim
    );
        logic [PROD_W:0]        rounded;
        logic [PROD_W-FRAC_W:0] mag;
        logic signed [PROD_W-FRAC_W+2:0] pos;
        rounded = {1'b0, prod} + (PROD_W+1)'(1 << (FRAC_W - 1));
        mag = rounded[PROD_W:FRAC_W];
        if (neg)
        begin
            pos = $signed((PROD_W-FRAC_W+3)'(base)) - $signed((PROD_W-FRAC_W+3)'(mag));
        end
        else
        begin
            pos = $signed((PROD_W-FRAC_W+3)'(base)) + $signed((PROD_W-FRAC_W+3)'(mag));
        end
        if (pos < 0 || pos >= $signed((PROD_W-FRAC_W+3)'(lim)))
        begin
            return base;
        end
        return pos[ROW_W-1:0];
    endfunction

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == S_PIX) && out_free;
    assign diff     = $signed({1'b0, height_q_reg}) - $signed({1'b0, hc_reg});
    assign diff_mag = diff[H_W] ? H_W'(-diff) : diff[H_W-1:0];
    assign sr_calc  = fix_coord(row_reg, neg_r_reg, prod_r_reg, dims.rows);
    assign sc_calc  = fix_coord(col_reg, neg_c_reg, prod_c_reg, dims.cols);

    always_comb
    begin
        state_next  = state_reg;
        q_pop       = 1'b0;
        frame_we    = 1'b0;
        frame_re    = 1'b0;
        frame_addr  = {q_head.row, q_head.col};
        height_we   = 1'b0;
        height_re   = 1'b0;
        height_addr = {q_head.row, q_head.col};
        case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop = 1'b1;
                    if (q_head.cmd == CMD_LOAD)
                    begin
                        frame_we  = 1'b1;
                        height_we = 1'b1;
                    end
                    else if (q_head.interior)
                    begin
                        height_re  = 1'b1;
                        state_next = S_HC;
                    end
                    else
                    begin
                        frame_re   = 1'b1;
                        state_next = S_PIX;
                    end
                end
            end
            S_HC:
            begin
                height_re   = 1'b1;
                height_addr = {row_reg + ROW_W'(1), col_reg};
                state_next  = S_HD;
            end
            S_HD:
            begin
                height_re   = 1'b1;
                height_addr = {row_reg, col_reg + COL_W'(1)};
                state_next  = S_HR;
            end
            S_HR:  state_next = S_ROW;
            S_ROW: state_next = S_COL;
            S_COL:
            begin
                frame_re   = 1'b1;
                frame_addr = {sr_reg, sc_calc};
                state_next = S_PIX;
            end
            S_PIX:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_addr] <= q_head.pixel;
        end
        else if (frame_re)
        begin
            frame_q_reg <= frame_mem[frame_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (height_we)
        begin
            height_mem[height_addr] <= q_head.height;
        end
        else if (height_re)
        begin
            height_q_reg <= height_mem[height_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_pop)
        begin
            row_reg <= q_head.row;
            col_reg <= q_head.col;
            sr_reg  <= q_head.row;
            sc_reg  <= q_head.col;
        end
        if (state_reg == S_HC)
        begin
            hc_reg <= height_q_reg;
        end
        if (state_reg == S_HD)
        begin
            coef_r_reg <= COEF_ROM[diff_mag];
            neg_r_reg  <= diff[H_W];
        end
        if (state_reg == S_HR)
        begin
            coef_c_reg <= COEF_ROM[diff_mag];
            neg_c_reg  <= diff[H_W];
            prod_r_reg <= PROD_W'(coef_r_reg) * PROD_W'(hc_reg);
        end
        if (state_reg == S_ROW)
        begin
            prod_c_reg <= PROD_W'(coef_c_reg) * PROD_W'(hc_reg);
            sr_reg     <= sr_calc;
        end
        if (state_reg == S_COL)
        begin
            sc_reg <= sc_calc;
        end
        if (out_load)
        begin
            pixel_out_reg <= frame_q_reg;
            src_row_reg   <= sr_reg;
            src_col_reg   <= sc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign src_row   = src_row_reg;
    assign src_col   = src_col_reg;

    `RDB_ASSERT_NEXT(a_b_pix_delivers, out_load, out_valid_reg && state_reg == S_IDLE,
        "finished word not presented")
    `RDB_ASSERT_NOW(a_b_mem_port, 1'b1, !(frame_we && frame_re) && !(height_we && height_re),
        "memory port used twice in one cycle")

endmodule

// ===== hw/rtl/refraction_displacement_blend.sv =====
`timescale 1ns / 1ps
// Water-refraction warp over a 128 x 128 frame held in on-chip memory.
// Input channel (in_valid/in_ready): one word per item. cmd = 0 loads
// pixel_in and height_in at (row, col) and returns nothing; cmd = 1 renders
// (row, col) and returns one output word (pixel_out, src_row, src_col).
// Configuration: APB-style writes set image_rows (0x0) and image_cols (0x4);
// both reset to 128 and read back as written. Write them only while idle.
// A load is written to both memories as it leaves the queue. A border render
// reads its pixel, then loads the output register. An interior render steps
// through its states (three height reads, two coefficient multiplies, one pixel
// read), set by the single-port height and frame memories and their sequencer.
// A two-word queue sits behind the input, so new words are taken while a
// result waits; the output register holds its word until out_ready.
// When the receiver stalls the back end holds in its final state, the queue
// fills, then in_ready drops. Reset empties the queue and output register;
// memory contents stay undefined until loaded, with no clearing pass.
module refraction_displacement_blend
    import rdb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [ROW_W-1:0]   row,
    input  logic [COL_W-1:0]   col,
    input  logic [PIX_W-1:0]   pixel_in,
    input  logic [H_W-1:0]     height_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIX_W-1:0]   pixel_out,
    output logic [ROW_W-1:0]   src_row,
    output logic [COL_W-1:0]   src_col
);

    logic [DIM_W-1:0]     rows_reg;
    logic [DIM_W-1:0]     cols_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    dims_t                dims;
    logic                 q_full;
    logic                 q_push;
    item_t                q_item;
    logic                 q_pop;
    logic                 q_not_empty;
    item_t                q_head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register write on the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_RESET;
            cols_reg <= DIM_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ROWS: rows_reg <= pwdata[DIM_W-1:0];
                REG_COLS: cols_reg <= pwdata[DIM_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ROWS: prdata = 32'(rows_reg);
            REG_COLS: prdata = 32'(cols_reg);
            default:  prdata = '0;
        endcase
    end

    // Clamp the frame size to the store.
    always_comb
    begin
        dims.rows = (rows_reg > DIM_RESET) ? DIM_RESET : rows_reg;
        dims.cols = (cols_reg > DIM_RESET) ? DIM_RESET : cols_reg;
    end

    rdb_front u_front
    (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .row       (row),
        .col       (col),
        .pixel_in  (pixel_in),
        .height_in (height_in),
        .dims      (dims),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    rdb_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    rdb_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .dims        (dims),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_out   (pixel_out),
        .src_row     (src_row),
        .src_col     (src_col)
    );

endmodule
